### design/fbfl_pkg.sv
// fbfl_pkg: widths, pool limits, command and status codes and register indexes
// for the fixed block free list allocator
// no dependencies
package fbfl_pkg;

  // pool limits
  localparam int MAX_BLOCKS   = 64;
  localparam int HEADER_BYTES = 8;

  // field widths
  localparam int IDX_W    = 6;
  localparam int CNT_W    = 7;
  localparam int BB_W     = 13;
  localparam int OFF_W    = 19;
  localparam int STRIDE_W = 14;
  localparam int CMD_W    = 2;
  localparam int STAT_W   = 2;

  // stream packing
  localparam int IN_DATA_W  = 8;
  localparam int OUT_USED_W = STAT_W + IDX_W + OFF_W + CNT_W;
  localparam int OUT_DATA_W = 40;

  // command codes
  localparam logic [CMD_W-1:0] CMD_INIT  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FREE  = 2'd2;

  // status codes
  localparam logic [STAT_W-1:0] STATUS_OK     = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_EMPTY  = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_REJECT = 2'd2;

  // configuration register indexes
  localparam logic REG_POOL_BLOCKS = 1'b0;
  localparam logic REG_BLOCK_BYTES = 1'b1;

endpackage

### design/fixed_block_free_list_allocator_top.sv
// Init writes each link entry in use in turn; allocate reads the head link, then
// runs the shift-add offset unit (one step per index bit up to its highest set
// bit); free runs only that unit; the result loads once the output is free.
// One item at a time: s_tready is high only while the sequencer is idle.
// Reset (rst, synchronous): pool empty, head 0, block count 64, block_bytes 64.
// The link memory has no reset; init writes every entry in use.
//
// fixed_block_free_list_allocator_top: lifo free list of block indices with
// a link memory and a shared shift-add unit for payload offsets
// depends on fbfl_pkg
module fixed_block_free_list_allocator_top
  import fbfl_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // slave side, tdata: command[1:0], block_index[7:2]
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // master side, tdata: status[1:0], granted_index[7:2], payload_offset[26:8],
  // free_count[33:27], zeros above
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,
  // configuration write port
  input  logic                  cfg_we,
  input  logic                  cfg_index,
  input  logic [BB_W-1:0]       cfg_data
);

  typedef enum logic [1:0] {
    IDLE,
    INIT,
    READ,
    MUL
  } state_t;

  state_t state;

  // configuration registers
  logic [CNT_W-1:0] pool_blocks;
  logic [BB_W-1:0]  block_bytes;

  // free list state
  logic [IDX_W-1:0] head_index;
  logic [CNT_W-1:0] free_total;
  logic [IDX_W-1:0] next_links [MAX_BLOCKS];
  logic [IDX_W-1:0] link_rd;

  // sequencer and shift-add unit
  logic [IDX_W-1:0]  walk_idx;
  logic [OFF_W-1:0]  acc;
  logic [OFF_W-1:0]  mcand;
  logic [IDX_W-1:0]  mplier;
  logic [STAT_W-1:0] res_status;
  logic [IDX_W-1:0]  res_granted;

  // output register
  logic [STAT_W-1:0] out_status;
  logic [IDX_W-1:0]  out_granted;
  logic [OFF_W-1:0]  out_offset;
  logic [CNT_W-1:0]  out_count;

  // decoded input
  logic [CMD_W-1:0]    in_cmd;
  logic [IDX_W-1:0]    in_idx;
  logic                in_take;
  logic [CNT_W-1:0]    pool_n;
  logic [STRIDE_W-1:0] stride;
  logic                walk_last;
  logic                out_free;
  logic                out_load;

  // memory write port
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  logic [IDX_W-1:0] mem_wdata;

  assign in_cmd  = s_tdata[CMD_W-1:0];
  assign in_idx  = s_tdata[CMD_W +: IDX_W];
  assign s_tready = (state == IDLE);
  assign in_take  = s_tvalid && s_tready;

  // block count saturated to 1..MAX_BLOCKS
  always_comb begin
    if (pool_blocks == '0) begin
      pool_n = CNT_W'(1);
    end else if (pool_blocks > CNT_W'(MAX_BLOCKS)) begin
      pool_n = CNT_W'(MAX_BLOCKS);
    end else begin
      pool_n = pool_blocks;
    end
  end

  assign stride    = STRIDE_W'(HEADER_BYTES) + STRIDE_W'(block_bytes);
  assign walk_last = ({1'b0, walk_idx} == (pool_n - CNT_W'(1)));
  assign out_free  = !m_tvalid || m_tready;
  assign out_load  = (state == MUL) && (mplier == '0) && out_free;

  // link memory write: init walk, or push on an accepted free
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = walk_idx;
    mem_wdata = walk_last ? '0 : walk_idx + IDX_W'(1);
    if (state == INIT) begin
      mem_we = 1'b1;
    end else if (in_take && in_cmd == CMD_FREE && free_total < pool_n
                 && {1'b0, in_idx} < pool_n) begin
      mem_we    = 1'b1;
      mem_waddr = in_idx;
      mem_wdata = head_index;
    end
  end

  // link memory, read port follows the head
  always_ff @(posedge clk) begin
    if (mem_we) begin
      next_links[mem_waddr] <= mem_wdata;
    end
    link_rd <= next_links[head_index];
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pool_blocks <= CNT_W'(64);
      block_bytes <= BB_W'(64);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_POOL_BLOCKS: pool_blocks <= cfg_data[CNT_W-1:0];
        REG_BLOCK_BYTES: block_bytes <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer, list state, shift-add unit and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= IDLE;
      head_index <= '0;
      free_total <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      // result valid: raised on load, dropped once taken
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (in_take) begin
            acc         <= '0;
            mcand       <= OFF_W'(stride);
            mplier      <= '0;
            res_status  <= STATUS_OK;
            res_granted <= '0;
            case (in_cmd)
              CMD_INIT: begin
                walk_idx <= '0;
                state    <= INIT;
              end
              CMD_ALLOC: begin
                if (free_total != '0) begin
                  res_granted <= head_index;
                  acc         <= OFF_W'(HEADER_BYTES);
                  mplier      <= head_index;
                  free_total  <= free_total - CNT_W'(1);
                  state       <= READ;
                end else begin
                  res_status <= STATUS_EMPTY;
                  state      <= MUL;
                end
              end
              CMD_FREE: begin
                if (free_total < pool_n && {1'b0, in_idx} < pool_n) begin
                  head_index  <= in_idx;
                  free_total  <= free_total + CNT_W'(1);
                  res_granted <= in_idx;
                  acc         <= OFF_W'(HEADER_BYTES);
                  mplier      <= in_idx;
                end else begin
                  res_status <= STATUS_REJECT;
                end
                state <= MUL;
              end
              default: state <= MUL;
            endcase
          end
        end
        INIT: begin
          walk_idx <= walk_idx + IDX_W'(1);
          if (walk_last) begin
            head_index <= '0;
            free_total <= pool_n;
            state      <= MUL;
          end
        end
        READ: begin
          // pop: head takes the link of the granted block
          head_index <= link_rd;
          state      <= MUL;
        end
        MUL: begin
          if (mplier != '0) begin
            if (mplier[0]) begin
              acc <= acc + mcand;
            end
            mcand  <= mcand << 1;
            mplier <= mplier >> 1;
          end else if (out_free) begin
            out_status  <= res_status;
            out_granted <= res_granted;
            out_offset  <= acc;
            out_count   <= free_total;
            state       <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  assign m_tdata = {{(OUT_DATA_W - OUT_USED_W){1'b0}}, out_count, out_offset,
                    out_granted, out_status};

  // checks on the sequencer and the list bookkeeping
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    free_total <= CNT_W'(MAX_BLOCKS))
    else $error("free count above pool limit");

  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    in_take |=> !s_tready)
    else $error("ready again right after an accepted item");

  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    out_load && res_status == STATUS_EMPTY |=> out_count == '0)
    else $error("empty pool reported with nonzero free count");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    out_load && res_status != STATUS_OK |=> out_granted == '0 && out_offset == '0)
    else $error("failed item carries an index or offset");

  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    out_load |-> out_free)
    else $error("output register overwritten while still held");

endmodule
